FILE: design/sfr_pkg.sv
// shared types and constants for the stream find/replace block
// no dependencies; used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package sfr_pkg;

    // widths of the data and configuration words
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned LEN_W     = 4;

    // hard limit on pattern and replacement length in bytes
    localparam int unsigned LEN_CAP = 8;

    // parameter defaults
    localparam int unsigned MAX_PATTERN_DEF = 8;
    localparam int unsigned MAX_REPLACE_DEF = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // append accepted byte to the window
        logic shift_emit;  // emit oldest window byte and shift the window
        logic match;       // full match: empty window, start replacement
        logic rep_emit;    // emit next replacement byte
        logic finish;      // close the run of results for this item
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic prefix_ok;   // window is a prefix of the pattern
        logic full_match;  // window equals the whole pattern
        logic cnt_zero;    // window is empty
        logic rep_done;    // all replacement bytes emitted
        logic end_flag;    // current item closes the stream
        logic held_valid;  // a result byte is held back
        logic out_free;    // output register can take a result this cycle
    } t_dp_stat;

endpackage

FILE: design/sfr_ctrl.sv
// controller state machine for the stream find/replace block
// depends on sfr_pkg; drives the datapath through t_dp_cmd
`timescale 1ns / 1ps

module sfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sfr_pkg::t_dp_stat i_stat,
    output sfr_pkg::t_dp_cmd  o_cmd
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REPL,
        ST_FLUSH,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_can_produce;
    logic   w_can_finish;

    // a new byte can be made when no held byte must first move out
    assign w_can_produce = !i_stat.held_valid || i_stat.out_free;
    assign w_can_finish  = i_stat.out_free || (!i_stat.held_valid && !i_stat.end_flag);

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.full_match) begin
                    o_cmd.match = 1'b1;
                    n_state     = ST_REPL;
                end else if (i_stat.prefix_ok) begin
                    n_state = i_stat.end_flag ? ST_FLUSH : ST_DONE;
                end else if (w_can_produce) begin
                    o_cmd.shift_emit = 1'b1;
                end
            end
            ST_REPL: begin
                if (i_stat.rep_done) begin
                    n_state = ST_DONE;
                end else if (w_can_produce) begin
                    o_cmd.rep_emit = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (i_stat.cnt_zero) begin
                    n_state = ST_DONE;
                end else if (w_can_produce) begin
                    o_cmd.shift_emit = 1'b1;
                end
            end
            ST_DONE: begin
                if (w_can_finish) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.shift_emit, o_cmd.match, o_cmd.rep_emit, o_cmd.finish}))
        else $error("sfr_ctrl: more than one datapath command");

    // closing a run returns to accepting input
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_in_ready)
        else $error("sfr_ctrl: not ready after finishing a run");

    // a full match always moves on to the replacement
    a_match_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.match |=> (r_state == ST_REPL))
        else $error("sfr_ctrl: match did not start replacement");

endmodule

FILE: design/sfr_datapath.sv
// datapath of the stream find/replace block: config registers, pending window,
// prefix compare, held result byte and output register; depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_datapath #(
    parameter int unsigned MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
    parameter int unsigned MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sfr_pkg::t_dp_cmd                  i_cmd,
    output sfr_pkg::t_dp_stat                 o_stat,
    input  logic [sfr_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                              i_stream_end,
    input  logic                              i_cfg_valid,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sfr_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                              o_byte_valid,
    output logic                              o_run_last,
    output logic                              o_text_end
);
    import sfr_pkg::*;

    localparam int unsigned PCAP = (MAX_PATTERN < LEN_CAP) ? MAX_PATTERN : LEN_CAP;
    localparam int unsigned RCAP = (MAX_REPLACE < LEN_CAP) ? MAX_REPLACE : LEN_CAP;
    localparam int unsigned CW   = $clog2(PCAP + 1);
    localparam int unsigned WIW  = (PCAP > 1) ? $clog2(PCAP) : 1;
    localparam int unsigned RW   = $clog2(RCAP + 1);

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                   input logic [LEN_W-1:0] lo,
                                                   input logic [LEN_W-1:0] hi);
        logic [LEN_W-1:0] r;
        begin
            r = v;
            if (r < lo) r = lo;
            if (r > hi) r = hi;
            return r;
        end
    endfunction

    // configuration registers
    logic [LEN_W-1:0]  r_pattern_len;
    logic [CFG_W-1:0]  r_pattern_bytes;
    logic [LEN_W-1:0]  r_replace_len;
    logic [CFG_W-1:0]  r_replace_bytes;

    // pending window and replacement position
    logic [BYTE_W-1:0] r_win [PCAP];
    logic [CW-1:0]     r_cnt;
    logic [RW-1:0]     r_rep_idx;
    logic              r_end;

    // held result byte and output register
    logic              r_held_valid;
    logic [BYTE_W-1:0] r_held_byte;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_byte_valid;
    logic              r_run_last;
    logic              r_text_end;

    logic [LEN_W-1:0]  w_plen;
    logic [LEN_W-1:0]  w_rlen;
    logic [LEN_W-1:0]  w_new_plen;
    logic [LEN_W-1:0]  w_cnt_ext;
    logic [LEN_W-1:0]  w_rep_ext;
    logic              w_prefix;
    logic [BYTE_W-1:0] w_rep_byte;
    logic [BYTE_W-1:0] w_prod_byte;
    logic              w_produce;
    logic              w_push;
    logic              w_out_free;
    logic              w_plen_wr;

    // effective lengths
    assign w_plen     = clamp_len(r_pattern_len, LEN_W'(1), LEN_W'(PCAP));
    assign w_rlen     = clamp_len(r_replace_len, LEN_W'(0), LEN_W'(RCAP));
    assign w_new_plen = clamp_len(i_cfg_data[LEN_W-1:0], LEN_W'(1), LEN_W'(PCAP));
    assign w_cnt_ext  = LEN_W'(r_cnt);
    assign w_rep_ext  = LEN_W'(r_rep_idx);
    assign w_plen_wr  = i_cfg_valid && (i_cfg_index == REG_PATTERN_LEN);

    // window against pattern, entries at or above the count are ignored
    always_comb begin
        w_prefix = 1'b1;
        for (int i = 0; i < PCAP; i++) begin
            if ((LEN_W'(i) < w_cnt_ext) && (r_win[i] != r_pattern_bytes[BYTE_W*i +: BYTE_W])) begin
                w_prefix = 1'b0;
            end
        end
    end

    // replacement byte and byte to produce
    assign w_rep_byte  = r_replace_bytes[{w_rep_ext[2:0], 3'b000} +: BYTE_W];
    assign w_prod_byte = i_cmd.rep_emit ? w_rep_byte : r_win[0];
    assign w_produce   = i_cmd.shift_emit || i_cmd.rep_emit;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_push      = (w_produce && r_held_valid)
                       || (i_cmd.finish && (r_held_valid || r_end));

    // status to the controller
    assign o_stat.prefix_ok  = w_prefix;
    assign o_stat.full_match = w_prefix && (w_cnt_ext == w_plen);
    assign o_stat.cnt_zero   = (r_cnt == '0);
    assign o_stat.rep_done   = (w_rep_ext >= w_rlen);
    assign o_stat.end_flag   = r_end;
    assign o_stat.held_valid = r_held_valid;
    assign o_stat.out_free   = w_out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_len   <= LEN_W'(1);
            r_pattern_bytes <= '0;
            r_replace_len   <= '0;
            r_replace_bytes <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PATTERN_LEN:   r_pattern_len   <= i_cfg_data[LEN_W-1:0];
                REG_PATTERN_BYTES: r_pattern_bytes <= i_cfg_data;
                REG_REPLACE_LEN:   r_replace_len   <= i_cfg_data[LEN_W-1:0];
                REG_REPLACE_BYTES: r_replace_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window count, end flag and replacement position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_end     <= 1'b0;
            r_rep_idx <= '0;
        end else begin
            if (w_plen_wr && (w_cnt_ext > (w_new_plen - LEN_W'(1)))) begin
                r_cnt <= CW'(w_new_plen - LEN_W'(1));
            end else if (i_cmd.load) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.shift_emit) begin
                r_cnt <= r_cnt - CW'(1);
            end else if (i_cmd.match) begin
                r_cnt <= '0;
            end
            if (i_cmd.load) begin
                r_end <= i_stream_end;
            end
            if (i_cmd.match) begin
                r_rep_idx <= '0;
            end else if (i_cmd.rep_emit) begin
                r_rep_idx <= r_rep_idx + RW'(1);
            end
        end
    end

    // window storage: append at the count, shift toward entry zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_win[r_cnt[WIW-1:0]] <= i_data_byte;
        end else if (i_cmd.shift_emit) begin
            for (int i = 0; i < PCAP - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
    end

    // held byte: one result is kept back until it is known whether it closes the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
        end else if (w_produce) begin
            r_held_valid <= 1'b1;
        end else if (i_cmd.finish) begin
            r_held_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_held_byte <= w_prod_byte;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            if (w_produce) begin
                r_out_byte   <= r_held_byte;
                r_byte_valid <= 1'b1;
                r_run_last   <= 1'b0;
                r_text_end   <= 1'b0;
            end else if (r_held_valid) begin
                r_out_byte   <= r_held_byte;
                r_byte_valid <= 1'b1;
                r_run_last   <= 1'b1;
                r_text_end   <= r_end;
            end else begin
                // empty end marker
                r_out_byte   <= '0;
                r_byte_valid <= 1'b0;
                r_run_last   <= 1'b1;
                r_text_end   <= 1'b1;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_run_last   = r_run_last;
    assign o_text_end   = r_text_end;

    // window never holds more bytes than the pattern
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_ext <= w_plen)
        else $error("sfr_datapath: window count above pattern length");

    // a result never overwrites one still waiting on the output
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_out_free)
        else $error("sfr_datapath: output register overwritten");

    // appending a byte leaves a non-empty window
    a_load_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !w_plen_wr) |=> (r_cnt != '0))
        else $error("sfr_datapath: window empty after append");

endmodule

FILE: design/stream_find_replace_all_top.sv
// Stream find/replace: replaces every leftmost, non-overlapping occurrence of
// the configured pattern (1 to 8 bytes) in a byte stream by the configured
// replacement (0 to 8 bytes); replacement text is never rescanned. Each input
// byte goes through a controller that checks the pending window against the
// pattern and emits result bytes in a loop, one per cycle unless the output
// stalls; the next input byte is taken only once the current one is finished.
// One result byte is held back so that its run-last flag is known; a stall on
// the output stalls the loop. A stream-end byte that leaves no text yields one
// result with byte_valid low. Configuration writes are taken every cycle and
// are meant for idle periods only; a shorter pattern length drops the newest
// pending bytes that no longer fit.
// depends on sfr_pkg, sfr_ctrl and sfr_datapath
`timescale 1ns / 1ps

module stream_find_replace_all_top #(
    parameter int unsigned MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
    parameter int unsigned MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input byte channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                              i_stream_end,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sfr_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                              o_byte_valid,
    output logic                              o_run_last,
    output logic                              o_text_end,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0]         i_cfg_data
);
    import sfr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_cfg_wr;

    // configuration writes are always accepted
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // controller
    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    sfr_datapath #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_REPLACE (MAX_REPLACE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .i_cfg_valid  (w_cfg_wr),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_last   (o_run_last),
        .o_text_end   (o_text_end)
    );

endmodule
